// ===== hw/rtl/rms_peak_dc_meter_macros.svh =====
// ---------------------------------------------------------------------------
// rms_peak_dc_meter assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ---------------------------------------------------------------------------
`ifndef RMS_PEAK_DC_METER_MACROS_SVH
`define RMS_PEAK_DC_METER_MACROS_SVH

// same-cycle implication
`define RPDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RPDM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rpdm_pkg.sv =====
// ---------------------------------------------------------------------------
// rpdm_pkg
// Types shared by the level meter controller, datapath and top level.
// ---------------------------------------------------------------------------
package rpdm_pkg;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0]        rms;
      logic [15:0]        peak;
      logic signed [15:0] dc_offset;
      logic [16:0]        sample_count;
      logic               overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_SETTLE,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic out_load;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic last_step;
      logic out_free;
   } sts_type;

endpackage

// ===== hw/rtl/rms_peak_dc_meter.sv =====
// ---------------------------------------------------------------------------
// rms_peak_dc_meter
// Block level meter for signed PCM samples. Each request carries a sample
// and a last flag; for each block one response gives the RMS (floor of the
// square root of the truncated mean square), the peak magnitude, the DC mean
// truncated toward zero, the number of samples taken and an overflow flag
// for samples dropped beyond MAX_SAMPLES. Samples other than the last are
// taken one per clock. After the last sample the request side is held off
// while a one-bit-per-cycle divider pair forms both means over SQ_W bits,
// the width of the sum of squares, and then a one-bit-per-cycle square root
// forms the RMS over RW = (SQ_W + 1) / 2 bits, and until the result moves
// into the output register. A finished response sits in that register, so
// the next block is taken while it waits; a further last sample waits only
// if it is still held.
// ---------------------------------------------------------------------------
module rms_peak_dc_meter #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rpdm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rpdm_pkg::rsp_type rsp_data
);
   import rpdm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rpdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rpdm_dpath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/rpdm_ctrl.sv =====
// ---------------------------------------------------------------------------
// rpdm_ctrl
// Sequencer: accumulate, settle, divide, square root, hand over result.
// ---------------------------------------------------------------------------
`include "rms_peak_dc_meter_macros.svh"

module rpdm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   output rpdm_pkg::cmd_type cmd,
   input  rpdm_pkg::sts_type sts
);
   import rpdm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_ROOT_INIT;
            end
         end
         ST_ROOT_INIT: begin
            cmd.root_load = 1'b1;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (sts.last_step) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         default: begin
            state_in = ST_ACCUM;
         end
      endcase
   end

   `RPDM_ASSERT_NEXT(a_last_starts_settle, req_valid && req_ready && req_last,
                     state_ff == ST_SETTLE, "last request did not start the result")
   `RPDM_ASSERT_NEXT(a_divide_to_root, (state_ff == ST_DIVIDE) && sts.last_step,
                     state_ff == ST_ROOT_INIT, "divide did not hand over to root")

endmodule

// ===== hw/rtl/rpdm_dpath.sv =====
// ---------------------------------------------------------------------------
// rpdm_dpath
// Square and magnitude stage, accumulators, bit-serial dividers,
// bit-serial square root and the result register.
// ---------------------------------------------------------------------------
`include "rms_peak_dc_meter_macros.svh"

module rpdm_dpath #(
   parameter int MAX_SAMPLES = 65536,
   parameter int SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  rpdm_pkg::req_type req_data,
   input  rpdm_pkg::cmd_type cmd,
   output rpdm_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rpdm_pkg::rsp_type rsp_data
);
   import rpdm_pkg::*;

   localparam int SW      = SAMPLE_BITS;
   localparam int CW      = $clog2(MAX_SAMPLES + 1);
   localparam int LW      = $clog2(MAX_SAMPLES);
   localparam int SQ_FULL = 2 * SW - 1 + LW;
   localparam int SQ_W    = (SQ_FULL > 64) ? 64 : SQ_FULL;
   localparam int OS_W    = SW + LW;
   localparam int RW      = (SQ_W + 1) / 2;
   localparam int ITER_W  = $clog2(SQ_W + 1);

   // input stage
   logic [SW-1:0]        raw;
   logic [SW-1:0]        mag;
   logic [2*SW-1:0]      sq_in;
   logic                 take;
   logic                 st_valid_ff;
   logic                 st_take_ff;
   logic [2*SW-1:0]      st_sq_ff;
   logic [SW-1:0]        st_mag_ff;
   logic signed [SW-1:0] st_s_ff;

   // accumulators
   logic [SQ_W-1:0]        sq_sum_ff, sq_sum_in;
   logic signed [OS_W-1:0] os_sum_ff, os_sum_in;
   logic [SW-1:0]          max_ff, max_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   drop_ff, drop_in;

   // dividers
   logic [SQ_W-1:0]   sq_q_ff, sq_q_in, dc_q_ff, dc_q_in;
   logic [CW-1:0]     sq_rem_ff, sq_rem_in, dc_rem_ff, dc_rem_in;
   logic              dc_neg_ff, dc_neg_in;
   logic [CW:0]       sq_sh, dc_sh;
   logic              sq_ge, dc_ge;
   logic [OS_W-1:0]   os_abs;

   // square root
   logic [2*RW-1:0]   rt_x_ff, rt_x_in;
   logic [RW:0]       rt_rem_ff, rt_rem_in;
   logic [RW-1:0]     rt_root_ff, rt_root_in;
   logic [RW+2:0]     rt_sh, rt_trial;
   logic              rt_ge;

   logic [ITER_W-1:0] iter_ff, iter_in;

   // result
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic signed [SQ_W:0] dc_val;

   assign raw   = SW'($unsigned(req_data.sample));
   assign mag   = raw[SW-1] ? (~raw + 1'b1) : raw;
   assign sq_in = {{SW{1'b0}}, mag} * {{SW{1'b0}}, mag};
   assign take  = count_ff < CW'(MAX_SAMPLES);

   assign os_abs = os_sum_ff[OS_W-1] ? (~$unsigned(os_sum_ff) + 1'b1) : $unsigned(os_sum_ff);

   assign sq_sh = {sq_rem_ff, sq_q_ff[SQ_W-1]};
   assign dc_sh = {dc_rem_ff, dc_q_ff[SQ_W-1]};
   assign sq_ge = sq_sh >= {1'b0, count_ff};
   assign dc_ge = dc_sh >= {1'b0, count_ff};

   assign rt_sh    = {rt_rem_ff, rt_x_ff[2*RW-1 -: 2]};
   assign rt_trial = {1'b0, rt_root_ff, 2'b01};
   assign rt_ge    = rt_sh >= rt_trial;

   assign dc_val = dc_neg_ff ? -$signed({1'b0, dc_q_ff}) : $signed({1'b0, dc_q_ff});

   always_comb begin
      sq_sum_in = sq_sum_ff;
      os_sum_in = os_sum_ff;
      max_in    = max_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      if (cmd.clear) begin
         sq_sum_in = '0;
         os_sum_in = '0;
         max_in    = '0;
         count_in  = '0;
         drop_in   = 1'b0;
      end else begin
         if (st_valid_ff && st_take_ff) begin
            sq_sum_in = sq_sum_ff + SQ_W'(st_sq_ff);
            os_sum_in = os_sum_ff + OS_W'(st_s_ff);
            if (st_mag_ff > max_ff) begin
               max_in = st_mag_ff;
            end
         end
         if (cmd.accept) begin
            if (take) begin
               count_in = count_ff + 1'b1;
            end else begin
               drop_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      sq_q_in    = sq_q_ff;
      dc_q_in    = dc_q_ff;
      sq_rem_in  = sq_rem_ff;
      dc_rem_in  = dc_rem_ff;
      dc_neg_in  = dc_neg_ff;
      rt_x_in    = rt_x_ff;
      rt_rem_in  = rt_rem_ff;
      rt_root_in = rt_root_ff;
      iter_in    = iter_ff;
      priority if (cmd.div_load) begin
         sq_q_in   = sq_sum_ff;
         dc_q_in   = SQ_W'(os_abs);
         dc_neg_in = os_sum_ff[OS_W-1];
         sq_rem_in = '0;
         dc_rem_in = '0;
         iter_in   = ITER_W'(SQ_W);
      end else if (cmd.div_step) begin
         sq_rem_in = sq_ge ? CW'(sq_sh - {1'b0, count_ff}) : CW'(sq_sh);
         dc_rem_in = dc_ge ? CW'(dc_sh - {1'b0, count_ff}) : CW'(dc_sh);
         sq_q_in   = {sq_q_ff[SQ_W-2:0], sq_ge};
         dc_q_in   = {dc_q_ff[SQ_W-2:0], dc_ge};
         iter_in   = iter_ff - 1'b1;
      end else if (cmd.root_load) begin
         rt_x_in    = (2*RW)'(sq_q_ff);
         rt_rem_in  = '0;
         rt_root_in = '0;
         iter_in    = ITER_W'(RW);
      end else if (cmd.root_step) begin
         rt_rem_in  = rt_ge ? (RW+1)'(rt_sh - rt_trial) : (RW+1)'(rt_sh);
         rt_root_in = {rt_root_ff[RW-2:0], rt_ge};
         rt_x_in    = {rt_x_ff[2*RW-3:0], 2'b00};
         iter_in    = iter_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_data_in              = rsp_data_ff;
      rsp_data_in.rms          = 16'(rt_root_ff);
      rsp_data_in.peak         = 16'(max_ff);
      rsp_data_in.dc_offset    = 16'(dc_val);
      rsp_data_in.sample_count = 17'(count_ff);
      rsp_data_in.overflow     = drop_ff;
      rsp_valid_in             = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sq_sum_ff    <= '0;
         os_sum_ff    <= '0;
         max_ff       <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         iter_ff      <= '0;
      end else begin
         st_valid_ff  <= cmd.accept;
         rsp_valid_ff <= rsp_valid_in;
         sq_sum_ff    <= sq_sum_in;
         os_sum_ff    <= os_sum_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         iter_ff      <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         st_take_ff <= take;
         st_sq_ff   <= sq_in;
         st_mag_ff  <= mag;
         st_s_ff    <= $signed(raw);
      end
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      sq_q_ff    <= sq_q_in;
      dc_q_ff    <= dc_q_in;
      sq_rem_ff  <= sq_rem_in;
      dc_rem_ff  <= dc_rem_in;
      dc_neg_ff  <= dc_neg_in;
      rt_x_ff    <= rt_x_in;
      rt_rem_ff  <= rt_rem_in;
      rt_root_ff <= rt_root_in;
   end

   assign sts.last_step = iter_ff == ITER_W'(1);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_data_ff;

   `RPDM_ASSERT_IMPLY(a_load_when_free, cmd.out_load, !rsp_valid_ff || rsp_ready,
                      "result register overwritten while full")
   `RPDM_ASSERT_IMPLY(a_count_bounded, 1'b1, count_ff <= CW'(MAX_SAMPLES),
                      "sample count above capacity")

endmodule
